[hdl/okl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_pkg: shared definitions for the ordered key list
// Request and status codes, field widths and the default list depth.
// ----------------------------------------------------------------------------
package okl_pkg;

  localparam int DEFAULT_DEPTH = 32;

  localparam int KEY_W    = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ITEM     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

endpackage

[hdl/okl_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_store: key storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module okl_store #(
  parameter int LIST_DEPTH = okl_pkg::DEFAULT_DEPTH,
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [okl_pkg::KEY_W-1:0]  wdata,
  input  logic [AW-1:0]                     raddr,
  output logic signed [okl_pkg::KEY_W-1:0]  rdata
);

  logic signed [okl_pkg::KEY_W-1:0] mem [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/okl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_ctrl: request sequencer
// Walks the key store one entry per cycle through a single compare unit:
// search, gap closing and dump, plus the registered result outputs.
// ----------------------------------------------------------------------------
module okl_ctrl #(
  parameter int LIST_DEPTH = okl_pkg::DEFAULT_DEPTH,
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [okl_pkg::REQ_W-1:0]           req_type,
  input  logic signed [okl_pkg::KEY_W-1:0]    key,
  output logic                                strobe,
  output logic signed [okl_pkg::KEY_W-1:0]    out_key,
  output logic [okl_pkg::STATUS_W-1:0]        status,
  output logic                                last,
  output logic                                mem_we,
  output logic [AW-1:0]                       mem_waddr,
  output logic signed [okl_pkg::KEY_W-1:0]    mem_wdata,
  output logic [AW-1:0]                       mem_raddr,
  input  logic signed [okl_pkg::KEY_W-1:0]    mem_rdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DUMP  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] pos, pos_next;
  logic signed [okl_pkg::KEY_W-1:0] key_r, key_next;

  logic strobe_next, last_next;
  logic signed [okl_pkg::KEY_W-1:0] out_key_next;
  logic [okl_pkg::STATUS_W-1:0] status_next;

  logic [CW-1:0] pos_inc;
  logic          at_tail;
  logic [AW-1:0] rd_ahead;

  // pos tracks the entry now on the read data; the read of pos+1 is issued ahead
  assign pos_inc  = CW'(pos) + CW'(1);
  assign at_tail  = (pos_inc == cnt);
  assign rd_ahead = (pos_inc < CW'(LIST_DEPTH)) ? pos_inc[AW-1:0] : '0;
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    pos_next     = pos;
    key_next     = key_r;
    strobe_next  = 1'b0;
    out_key_next = out_key;
    status_next  = status;
    last_next    = last;
    mem_we       = 1'b0;
    mem_waddr    = pos;
    mem_wdata    = key;
    mem_raddr    = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            okl_pkg::REQ_APPEND: begin
              strobe_next  = 1'b1;
              out_key_next = key;
              last_next    = 1'b1;
              if (cnt == CW'(LIST_DEPTH)) begin
                status_next = okl_pkg::ST_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = cnt[AW-1:0];
                mem_wdata   = key;
                cnt_next    = cnt + CW'(1);
                status_next = okl_pkg::ST_APPENDED;
              end
            end
            okl_pkg::REQ_DELETE: begin
              if (cnt == '0) begin
                strobe_next  = 1'b1;
                out_key_next = key;
                status_next  = okl_pkg::ST_NOTFOUND;
                last_next    = 1'b1;
              end else begin
                key_next   = key;
                pos_next   = '0;
                state_next = S_SCAN;
              end
            end
            okl_pkg::REQ_DUMP: begin
              if (cnt == '0) begin
                strobe_next  = 1'b1;
                out_key_next = '0;
                status_next  = okl_pkg::ST_EMPTY;
                last_next    = 1'b1;
              end else begin
                pos_next   = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_raddr = rd_ahead;
        if (mem_rdata == key_r) begin
          if (at_tail) begin
            cnt_next     = cnt - CW'(1);
            strobe_next  = 1'b1;
            out_key_next = key_r;
            status_next  = okl_pkg::ST_DELETED;
            last_next    = 1'b1;
            state_next   = S_IDLE;
          end else begin
            pos_next   = pos + AW'(1);
            state_next = S_SHIFT;
          end
        end else if (at_tail) begin
          strobe_next  = 1'b1;
          out_key_next = key_r;
          status_next  = okl_pkg::ST_NOTFOUND;
          last_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          pos_next = pos + AW'(1);
        end
      end
      S_SHIFT: begin
        // move entry pos down one place
        mem_we    = 1'b1;
        mem_waddr = pos - AW'(1);
        mem_wdata = mem_rdata;
        mem_raddr = rd_ahead;
        if (at_tail) begin
          cnt_next     = cnt - CW'(1);
          strobe_next  = 1'b1;
          out_key_next = key_r;
          status_next  = okl_pkg::ST_DELETED;
          last_next    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          pos_next = pos + AW'(1);
        end
      end
      S_DUMP: begin
        mem_raddr    = rd_ahead;
        strobe_next  = 1'b1;
        out_key_next = mem_rdata;
        status_next  = okl_pkg::ST_ITEM;
        last_next    = at_tail;
        if (at_tail) begin
          state_next = S_IDLE;
        end else begin
          pos_next = pos + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    key_r   <= key_next;
    out_key <= out_key_next;
    status  <= status_next;
    last    <= last_next;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> state == S_IDLE)
    else $error("final result while still walking the list");

  a_del_count: assert property (@(posedge clk) disable iff (rst)
    strobe && status == okl_pkg::ST_DELETED |-> cnt == $past(cnt) - CW'(1))
    else $error("delete did not shrink the list by one");

  a_app_count: assert property (@(posedge clk) disable iff (rst)
    strobe && status == okl_pkg::ST_APPENDED |-> cnt == $past(cnt) + CW'(1))
    else $error("append did not grow the list by one");

  a_write_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_SHIFT || (state == S_IDLE && start))
    else $error("key store written outside append or gap closing");

endmodule

[hdl/ordered_key_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_list: bounded ordered list of signed keys
// Append at the tail, delete first match with gap closing, dump head to tail.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low. An append (or any
// request on an empty list) is handled while idle and leaves busy low. A delete
// or dump on n entries holds busy while all n are walked: the single read port
// of the key store is stepped one entry per cycle, through search and gap
// closing alike. Each result is shown on out_key/status/last for one cycle with
// strobe high, the cycle after it is decided; a dump gives one result per cycle
// and the receiver must take every one, since nothing can hold results back.
module ordered_key_list #(
  parameter int LIST_DEPTH = okl_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [okl_pkg::REQ_W-1:0]         req_type,
  input  logic signed [okl_pkg::KEY_W-1:0]  key,
  output logic                              strobe,
  output logic signed [okl_pkg::KEY_W-1:0]  out_key,
  output logic [okl_pkg::STATUS_W-1:0]      status,
  output logic                              last
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic signed [okl_pkg::KEY_W-1:0] mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  logic signed [okl_pkg::KEY_W-1:0] mem_rdata;

  okl_ctrl #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .key      (key),
    .strobe   (strobe),
    .out_key  (out_key),
    .status   (status),
    .last     (last),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  okl_store #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
